// ----- design/pc_sample_region_profiler_unit_defines.svh -----
// Assertion macros shared by the profiler checker.
// No dependencies.
`ifndef PC_SAMPLE_REGION_PROFILER_UNIT_DEFINES_SVH
`define PC_SAMPLE_REGION_PROFILER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PSRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define PSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/psrp_pkg.sv -----
// Types and constants of the PC sample region profiler.
// No dependencies.
package psrp_pkg;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned ID_W   = 4;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_LOAD   = 2'd2,
        REQ_REPORT = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_CMP, ST_SAMPLE_OUT, ST_CLEAR, ST_SORT_INIT,
        ST_SORT_RD, ST_SORT_CMP, ST_EMIT_RD, ST_EMIT_OUT, ST_SIMPLE_OUT
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [WORD_W-1:0] pc_addr;
        logic [ID_W-1:0]   entry_index;
        logic [WORD_W-1:0] start_addr;
        logic [WORD_W-1:0] end_addr;
    } t_req_item;

    typedef struct packed {
        logic [KIND_W-1:0] resp_kind;
        logic [ID_W-1:0]   region_id;
        logic              hit;
        logic [WORD_W-1:0] hit_count;
        logic [WORD_W-1:0] total_samples;
        logic [WORD_W-1:0] lost_samples;
        logic [WORD_W-1:0] last_lost;
        logic              last;
    } t_resp_item;
endpackage

// ----- design/psrp_if.sv -----
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on psrp_pkg.
interface psrp_req_if;
    logic valid;
    logic ready;
    psrp_pkg::t_req_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psrp_resp_if;
    logic valid;
    logic ready;
    psrp_pkg::t_resp_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psrp_cfg_if;
    logic valid;
    logic ready;
    logic [psrp_pkg::CFG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/pc_sample_region_profiler_unit.sv -----
// Top level of the PC sample region profiler: region table, counters, sequencer.
// Depends on psrp_pkg and psrp_if.
//
//  channel   direction  beat
//  i_req     in         one request (sample, clear, load, report)
//  o_resp    out        one result; last marks the final one of a request
//  i_cfg     in         regions_in_use write
//
// A sample checks table entries in turn until a hit or the last region in use; the shared
// comparator checks one table entry per pass. Clear resets the counters (one counter
// row a cycle) and load writes the addressed table entry. A report seeds the order,
// compares and swaps pairs through the same comparator, then reads out each result.
// Requests are not taken while one is in progress; a stalled result holds the
// sequencer. Reset clears counters before the first request.
module pc_sample_region_profiler_unit #(
    parameter int unsigned MAX_REGIONS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    psrp_req_if.sink    i_req,
    psrp_resp_if.source o_resp,
    psrp_cfg_if.sink    i_cfg
);
    import psrp_pkg::*;

    localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

    logic [WORD_W-1:0] lo_mem [MAX_REGIONS];
    logic [WORD_W-1:0] hi_mem [MAX_REGIONS];
    logic [WORD_W-1:0] hit_mem [MAX_REGIONS];
    logic [AW-1:0]     rank_mem [MAX_REGIONS];

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    t_req_item r_req;
    logic [WORD_W-1:0] r_total, r_lost, r_lost_addr;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [CW-1:0] act_n;
    logic [WORD_W-1:0] r_lo_q, r_hi_q, r_hit_q, r_cnt_a;
    logic [AW-1:0] r_rank_a, r_rank_b;
    logic r_rd_phase, n_rd_phase;
    logic r_out_valid;
    t_resp_item r_out;

    // Memory control from the sequencer.
    logic hit_we, rank_we_a, rank_we_b;
    logic [AW-1:0] hit_waddr, hit_raddr, rank_raddr;
    logic [WORD_W-1:0] hit_wdata;
    logic rank_rd;
    logic [AW-1:0] rank_wa_addr, rank_wa_data, rank_wb_addr, rank_wb_data;
    logic load_we;
    logic emit;
    t_resp_item emit_item;

    assign act_n = (32'(r_cfg) > MAX_REGIONS) ? CW'(MAX_REGIONS) : CW'(r_cfg);
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_resp.valid = r_out_valid;
    assign o_resp.data  = r_out;

    logic out_free;
    assign out_free = !r_out_valid || o_resp.ready;

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            lo_mem[r_req.entry_index[AW-1:0]] <= r_req.start_addr;
            hi_mem[r_req.entry_index[AW-1:0]] <= r_req.end_addr;
        end
        r_lo_q <= lo_mem[r_i[AW-1:0]];
        r_hi_q <= hi_mem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (hit_we) hit_mem[hit_waddr] <= hit_wdata;
        r_hit_q <= hit_mem[hit_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we_a) rank_mem[rank_wa_addr] <= rank_wa_data;
        if (rank_we_b) rank_mem[rank_wb_addr] <= rank_wb_data;
        if (rank_rd) r_rank_a <= rank_mem[rank_raddr];
    end

    // Single compare unit shared by the region lower-bound check and sort ordering.
    logic [WORD_W-1:0] cmp_a, cmp_b;
    logic cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;
    logic pc_ge_lo, pc_le_hi;
    always_comb begin
        cmp_a = r_cnt_a;
        cmp_b = r_hit_q;
        if (r_state == ST_SCAN_CMP) begin
            cmp_a = r_req.pc_addr;
            cmp_b = r_lo_q & ~WORD_W'(1);
        end
    end
    assign pc_ge_lo = !cmp_lt;
    assign pc_le_hi = r_req.pc_addr <= r_hi_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cfg <= '0;
            r_i <= '0;
            r_j <= '0;
            r_rd_phase <= 1'b0;
            r_out_valid <= 1'b0;
            r_total <= '0;
            r_lost <= '0;
            r_lost_addr <= '0;
        end else begin
            if (i_cfg.valid) r_cfg <= i_cfg.data;
            r_state <= n_state;
            r_i <= n_i;
            r_j <= n_j;
            r_rd_phase <= n_rd_phase;
            if (emit) r_out_valid <= 1'b1;
            else if (o_resp.ready) r_out_valid <= 1'b0;
            if (r_state == ST_CLEAR && r_i == '0 && r_req.req_type == REQ_CLEAR) begin
                r_total <= '0;
                r_lost <= '0;
                r_lost_addr <= '0;
            end
            if (r_state == ST_SAMPLE_OUT && out_free) begin
                r_total <= r_total + 1'b1;
                if (!r_req.entry_index[0]) begin
                    r_lost <= r_lost + 1'b1;
                    r_lost_addr <= r_req.pc_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_req <= '0;
        else if (r_state == ST_IDLE && i_req.valid) r_req <= i_req.data;
        else if (r_state == ST_SCAN_CMP && pc_ge_lo && pc_le_hi) begin
            r_req.entry_index[0] <= 1'b1;   // reused as the found flag
            r_req.start_addr <= WORD_W'(r_i);
        end else if (r_state == ST_SCAN && r_i == '0) r_req.entry_index[0] <= 1'b0;
        if (r_state == ST_SORT_CMP && !r_rd_phase) r_cnt_a <= r_hit_q;
        if (emit) r_out <= emit_item;
        if (r_state == ST_SORT_RD && r_rd_phase) r_rank_b <= r_rank_a;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_rd_phase = 1'b0;
        hit_we = 1'b0;
        hit_waddr = r_i[AW-1:0];
        hit_wdata = '0;
        hit_raddr = r_i[AW-1:0];
        rank_rd = 1'b0;
        rank_raddr = r_i[AW-1:0];
        rank_we_a = 1'b0;
        rank_we_b = 1'b0;
        rank_wa_addr = r_i[AW-1:0];
        rank_wa_data = '0;
        rank_wb_addr = r_j[AW-1:0];
        rank_wb_data = '0;
        load_we = 1'b0;
        emit = 1'b0;
        emit_item = '0;
        emit_item.total_samples = r_total;
        emit_item.lost_samples = r_lost;
        emit_item.last_lost = r_lost_addr;
        emit_item.last = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                n_i = '0;
                if (i_req.valid) begin
                    unique case (t_req'(i_req.data.req_type))
                        REQ_SAMPLE: n_state = ST_SCAN;
                        REQ_CLEAR:  n_state = ST_CLEAR;
                        REQ_LOAD:   n_state = ST_SIMPLE_OUT;
                        REQ_REPORT: n_state = ST_SORT_INIT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_i >= act_n) n_state = ST_SAMPLE_OUT;
                else n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (pc_ge_lo && pc_le_hi) n_state = ST_SAMPLE_OUT;
                else begin
                    n_i = r_i + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SAMPLE_OUT: begin
                hit_raddr = r_req.start_addr[AW-1:0];
                if (out_free) begin
                    emit = 1'b1;
                    emit_item.total_samples = r_total + 1'b1;
                    emit_item.resp_kind = REQ_SAMPLE;
                    if (r_req.entry_index[0]) begin
                        hit_we = 1'b1;
                        hit_waddr = r_req.start_addr[AW-1:0];
                        hit_wdata = r_hit_q + 1'b1;
                        emit_item.region_id = ID_W'(r_req.start_addr[AW-1:0]);
                        emit_item.hit = 1'b1;
                        emit_item.hit_count = r_hit_q + 1'b1;
                    end else begin
                        emit_item.lost_samples = r_lost + 1'b1;
                        emit_item.last_lost = r_req.pc_addr;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                hit_we = 1'b1;
                n_i = r_i + 1'b1;
                if (r_i == CW'(MAX_REGIONS - 1)) begin
                    n_i = '0;
                    n_state = (r_req.req_type == REQ_CLEAR) ? ST_SIMPLE_OUT : ST_IDLE;
                end
            end
            ST_SIMPLE_OUT: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_item.resp_kind = r_req.req_type;
                    if (r_req.req_type == REQ_CLEAR) begin
                        emit_item.total_samples = '0;
                        emit_item.lost_samples = '0;
                        emit_item.last_lost = '0;
                    end
                    load_we = (r_req.req_type == REQ_LOAD) &&
                              (32'(r_req.entry_index) < MAX_REGIONS);
                    n_state = ST_IDLE;
                end
            end
            ST_SORT_INIT: begin
                rank_we_a = (r_i < act_n);
                rank_wa_data = r_i[AW-1:0];
                n_i = r_i + 1'b1;
                if (r_i >= act_n) begin
                    n_i = '0;
                    n_j = CW'(1);
                    n_state = (act_n == '0) ? ST_IDLE : ST_SORT_RD;
                end
            end
            ST_SORT_RD: begin
                // Phase 0 reads rank[i]; phase 1 reads rank[j] and hits[rank[i]].
                if (r_j >= act_n) begin
                    n_i = r_i + 1'b1;
                    n_j = r_i + 2'd2;
                    if (r_i + 1'b1 >= act_n) begin
                        n_i = '0;
                        n_state = ST_EMIT_RD;
                    end
                end else if (!r_rd_phase) begin
                    rank_rd = 1'b1;
                    rank_raddr = r_i[AW-1:0];
                    n_rd_phase = 1'b1;
                end else begin
                    hit_raddr = r_rank_a;
                    rank_rd = 1'b1;
                    rank_raddr = r_j[AW-1:0];
                    n_state = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                // Phase 0 latches hits[rank[i]] and reads hits[rank[j]]; phase 1
                // compares and swaps the pair when rank[i] has the smaller count.
                if (!r_rd_phase) begin
                    hit_raddr = r_rank_a;
                    n_rd_phase = 1'b1;
                end else begin
                    rank_we_a = cmp_lt;
                    rank_wa_data = r_rank_a;
                    rank_we_b = cmp_lt;
                    rank_wb_data = r_rank_b;
                    n_j = r_j + 1'b1;
                    n_state = ST_SORT_RD;
                end
            end
            ST_EMIT_RD: begin
                rank_rd = 1'b1;
                rank_raddr = r_i[AW-1:0];
                n_state = ST_EMIT_OUT;
                n_rd_phase = 1'b0;
            end
            ST_EMIT_OUT: begin
                hit_raddr = r_rank_a;
                if (!r_rd_phase) n_rd_phase = 1'b1;
                else begin
                    n_rd_phase = 1'b1;
                    if (out_free) begin
                        emit = 1'b1;
                        emit_item.resp_kind = REQ_REPORT;
                        emit_item.region_id = ID_W'(r_rank_a);
                        emit_item.hit_count = r_hit_q;
                        emit_item.last = (r_i + 1'b1 == act_n);
                        n_i = r_i + 1'b1;
                        n_rd_phase = 1'b0;
                        n_state = (r_i + 1'b1 == act_n) ? ST_IDLE : ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- design/psrp_checker.sv -----
// Port-level checker for the profiler, bound to the top level.
// Depends on psrp_pkg and the defines header.
`include "pc_sample_region_profiler_unit_defines.svh"
module psrp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic resp_valid,
    input logic resp_ready,
    input logic resp_hit,
    input logic [1:0] resp_kind
);
    import psrp_pkg::*;
    `PSRP_ASSERT_NEXT(a_busy, i_clk, i_rst_n, req_valid && req_ready, !req_ready, "ready stayed after accept")
    `PSRP_ASSERT_IMP(a_hit_kind, i_clk, i_rst_n, resp_valid && resp_hit, resp_kind == REQ_SAMPLE, "hit on non-sample")
    `PSRP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, resp_valid && !resp_ready, resp_valid, "result dropped")
endmodule

bind pc_sample_region_profiler_unit psrp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .resp_valid(o_resp.valid), .resp_ready(o_resp.ready),
    .resp_hit(o_resp.data.hit), .resp_kind(o_resp.data.resp_kind)
);
